// ===== rtl/csf_pkg.sv =====
// shared types and constants for the chunked sample fifo
`default_nettype none

package csf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 16;
    localparam int QCOUNT_W    = 13;
    localparam int CAP_W       = 13;
    localparam int MAXC_W      = 7;
    localparam int TDATA_W     = 32;
    localparam int TUSER_IN_W  = 3;
    localparam int TUSER_OUT_W = 3;
    localparam int PAD_W       = TDATA_W - QCOUNT_W - SAMPLE_W;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 13'd4096;
    localparam logic [MAXC_W-1:0] MAXC_RESET = 7'd64;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED    = 3'd0,
        KIND_OVF_START   = 3'd1,
        KIND_OVF_ONGOING = 3'd2,
        KIND_POPPED      = 3'd3,
        KIND_POP_EMPTY   = 3'd4
    } kind_t;

    typedef enum logic {
        CFG_CAPACITY  = 1'b0,
        CFG_MAX_CHUNK = 1'b1
    } cfg_idx_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic push_sample;
        logic clear;
        logic cut;
        logic admit;
        logic pop_start;
        logic pop_len;
        logic pop_finish;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic no_chunk;
        logic stream_done;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/csf_ctrl.sv =====
// controller state machine of the chunked sample fifo
`default_nettype none

module csf_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire csf_pkg::req_t   req,
    input  wire logic            first,
    input  wire csf_pkg::status_t status,
    output csf_pkg::cmd_t        cmd
);
    import csf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CUT     = 6'b000010,
        S_ADMIT   = 6'b000100,
        S_POP     = 6'b001000,
        S_POP_LEN = 6'b010000,
        S_STREAM  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.accept = 1'b1;
                    case (req)
                        REQ_PUSH: begin
                            if (first) begin
                                state_next = S_CUT;
                            end else begin
                                cmd.push_sample = 1'b1;
                            end
                        end
                        REQ_POP: begin
                            state_next = S_POP;
                        end
                        REQ_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CUT: begin
                cmd.cut    = 1'b1;
                state_next = S_ADMIT;
            end
            S_ADMIT: begin
                cmd.admit  = 1'b1;
                state_next = S_IDLE;
            end
            S_POP: begin
                cmd.pop_start = 1'b1;
                state_next    = status.no_chunk ? S_IDLE : S_POP_LEN;
            end
            S_POP_LEN: begin
                cmd.pop_len = 1'b1;
                state_next  = S_STREAM;
            end
            S_STREAM: begin
                if (status.stream_done) begin
                    cmd.pop_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/csf_datapath.sv =====
// datapath: sample store, chunk length queue, counters and output register
`default_nettype none

module csf_datapath #(
    parameter int STORE_DEPTH = 4096,
    parameter int CHUNK_LIMIT = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire csf_pkg::cmd_t                       cmd,
    output csf_pkg::status_t                         status,
    input  wire logic signed [csf_pkg::SAMPLE_W-1:0] smp_in,
    input  wire logic [csf_pkg::LEN_W-1:0]           len_in,
    input  wire logic                                cfg_valid,
    input  wire csf_pkg::cfg_idx_t                   cfg_index,
    input  wire logic [csf_pkg::CAP_W-1:0]           cfg_data,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [csf_pkg::TDATA_W-1:0]              m_tdata,
    output logic [csf_pkg::TUSER_OUT_W-1:0]          m_tuser,
    output logic                                     m_tlast
);
    import csf_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QW = $clog2(STORE_DEPTH + 1);
    localparam int FW = $clog2(CHUNK_LIMIT + 1);
    localparam int XW = ((QW > LEN_W) ? QW : LEN_W) + 1;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(STORE_DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    // memories
    logic signed [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
    logic [FW-1:0]              len_mem   [STORE_DEPTH];

    // control registers
    logic [AW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [AW-1:0]     lwp_reg, lwp_next, lrp_reg, lrp_next;
    logic [QW-1:0]     queued_reg, queued_next;
    logic [QW-1:0]     cc_reg, cc_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  pr_reg, pr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [MAXC_W-1:0] mc_reg, mc_next;
    logic [FW-1:0]     issue_reg, issue_next;
    logic              v1_reg, v1_next;
    logic              mvalid_reg, mvalid_next;

    // payload registers
    logic signed [SAMPLE_W-1:0] item_smp_reg;
    logic [LEN_W-1:0]           item_len_reg;
    logic signed [SAMPLE_W-1:0] sdata_reg;
    logic                       v1_last_reg;
    logic [FW-1:0]              len_rd_reg;
    kind_t                      out_kind_reg, out_kind_next;
    logic signed [SAMPLE_W-1:0] out_smp_reg, out_smp_next;
    logic                       out_last_reg, out_last_next;
    logic [QCOUNT_W-1:0]        out_q_reg, out_q_next;

    // combinational helpers
    logic [XW-1:0]              cap_ext, cap_eff, q_ext, pr_ext, lr_ext;
    logic [MAXC_W-1:0]          chunk_eff;
    logic [FW-1:0]              fill_inc, len_wdata;
    logic [LEN_W-1:0]           wr_pr;
    logic signed [SAMPLE_W-1:0] wr_smp;
    logic                       wr_end, wr_go, refuse, admit_ok;
    logic                       store_we, store_re, len_we, len_re, load_out;
    logic                       out_free, adv, issue;
    logic [QW-1:0]              q_cut, q_after, q_admit;

    assign cap_ext   = XW'(cap_reg);
    assign cap_eff   = (cap_ext == '0) ? XW'(1) :
                       ((cap_ext > XW'(STORE_DEPTH)) ? XW'(STORE_DEPTH) : cap_ext);
    assign chunk_eff = (mc_reg == '0) ? MAXC_W'(1) :
                       ((mc_reg > MAXC_W'(CHUNK_LIMIT)) ? MAXC_W'(CHUNK_LIMIT) : mc_reg);

    assign q_ext  = XW'(queued_reg);
    assign pr_ext = XW'(pr_reg);
    assign lr_ext = XW'(len_rd_reg);

    assign fill_inc = FW'(fill_reg + 1'b1);
    assign wr_pr    = cmd.admit ? item_len_reg : pr_reg;
    assign wr_smp   = cmd.admit ? item_smp_reg : smp_in;
    assign wr_end   = (MAXC_W'(fill_inc) >= chunk_eff) || (wr_pr == LEN_W'(1));
    // whole packet must fit the free space left under the capacity
    assign refuse   = (XW'(item_len_reg) + q_ext) > cap_eff;
    assign admit_ok = (item_len_reg != '0) && !refuse;
    assign wr_go    = (cmd.push_sample && (pr_reg != '0)) || (cmd.admit && admit_ok);

    assign q_cut   = (q_ext > pr_ext) ? QW'(q_ext - pr_ext) : '0;
    assign q_after = (q_ext > lr_ext) ? QW'(q_ext - lr_ext) : '0;
    assign q_admit = QW'(q_ext + XW'(item_len_reg));

    assign out_free = !mvalid_reg || m_tready;
    assign adv      = v1_reg && out_free;
    assign issue    = (issue_reg != '0) && (!v1_reg || adv);

    assign status.out_free    = out_free;
    assign status.no_chunk    = (cc_reg == '0);
    assign status.stream_done = (issue_reg == '0) && !v1_reg;

    always_comb begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        lwp_next      = lwp_reg;
        lrp_next      = lrp_reg;
        queued_next   = queued_reg;
        cc_next       = cc_reg;
        ovf_next      = ovf_reg;
        pr_next       = pr_reg;
        fill_next     = fill_reg;
        cap_next      = cap_reg;
        mc_next       = mc_reg;
        issue_next    = issue_reg;
        store_we      = 1'b0;
        store_re      = 1'b0;
        len_we        = 1'b0;
        len_re        = 1'b0;
        len_wdata     = fill_inc;
        load_out      = 1'b0;
        out_kind_next = KIND_ACCEPTED;
        out_smp_next  = '0;
        out_last_next = 1'b1;
        out_q_next    = QCOUNT_W'(queued_reg);

        if (cfg_valid) begin
            case (cfg_index)
                CFG_CAPACITY:  cap_next = cfg_data;
                CFG_MAX_CHUNK: mc_next  = cfg_data[MAXC_W-1:0];
                default: begin
                end
            endcase
        end

        // a new packet head closes whatever is left of the previous one
        if (cmd.cut && (pr_reg != '0)) begin
            queued_next = q_cut;
            pr_next     = '0;
            if (fill_reg != '0) begin
                len_we    = 1'b1;
                len_wdata = fill_reg;
                lwp_next  = ptr_inc(lwp_reg);
                cc_next   = QW'(cc_reg + 1'b1);
                fill_next = '0;
            end
        end

        if (cmd.admit) begin
            load_out = 1'b1;
            if ((item_len_reg != '0) && refuse) begin
                out_kind_next = ovf_reg ? KIND_OVF_ONGOING : KIND_OVF_START;
                ovf_next      = 1'b1;
            end else if (admit_ok) begin
                queued_next = q_admit;
                out_q_next  = QCOUNT_W'(q_admit);
            end
        end

        if (wr_go) begin
            store_we = 1'b1;
            wp_next  = ptr_inc(wp_reg);
            pr_next  = LEN_W'(wr_pr - 1'b1);
            if (wr_end) begin
                len_we    = 1'b1;
                len_wdata = fill_inc;
                lwp_next  = ptr_inc(lwp_reg);
                cc_next   = QW'(cc_reg + 1'b1);
                fill_next = '0;
            end else begin
                fill_next = fill_inc;
            end
        end

        if (cmd.pop_start) begin
            if (cc_reg == '0) begin
                load_out      = 1'b1;
                out_kind_next = KIND_POP_EMPTY;
            end else begin
                len_re   = 1'b1;
                lrp_next = ptr_inc(lrp_reg);
                cc_next  = QW'(cc_reg - 1'b1);
            end
        end

        // every sample of the pop shows the count left after the whole chunk
        if (cmd.pop_len) begin
            queued_next = q_after;
            issue_next  = len_rd_reg;
        end

        if (issue) begin
            store_re   = 1'b1;
            rp_next    = ptr_inc(rp_reg);
            issue_next = FW'(issue_reg - 1'b1);
        end

        if (adv) begin
            load_out      = 1'b1;
            out_kind_next = KIND_POPPED;
            out_smp_next  = sdata_reg;
            out_last_next = v1_last_reg;
        end

        if (cmd.pop_finish && ovf_reg && (q_ext <= ((cap_eff - 1'b1) >> 1))) begin
            ovf_next = 1'b0;
        end

        if (cmd.clear) begin
            wp_next     = '0;
            rp_next     = '0;
            lwp_next    = '0;
            lrp_next    = '0;
            queued_next = '0;
            cc_next     = '0;
            ovf_next    = 1'b0;
            pr_next     = '0;
            fill_next   = '0;
        end

        v1_next     = issue || (v1_reg && !adv);
        mvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            lwp_reg    <= '0;
            lrp_reg    <= '0;
            queued_reg <= '0;
            cc_reg     <= '0;
            ovf_reg    <= 1'b0;
            pr_reg     <= '0;
            fill_reg   <= '0;
            cap_reg    <= CAP_RESET;
            mc_reg     <= MAXC_RESET;
            issue_reg  <= '0;
            v1_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            lwp_reg    <= lwp_next;
            lrp_reg    <= lrp_next;
            queued_reg <= queued_next;
            cc_reg     <= cc_next;
            ovf_reg    <= ovf_next;
            pr_reg     <= pr_next;
            fill_reg   <= fill_next;
            cap_reg    <= cap_next;
            mc_reg     <= mc_next;
            issue_reg  <= issue_next;
            v1_reg     <= v1_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_smp_reg <= smp_in;
            item_len_reg <= len_in;
        end
        if (issue) begin
            v1_last_reg <= (issue_reg == FW'(1));
        end
        if (load_out) begin
            out_kind_reg <= out_kind_next;
            out_smp_reg  <= out_smp_next;
            out_last_reg <= out_last_next;
            out_q_reg    <= out_q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[wp_reg] <= wr_smp;
        end
        if (store_re) begin
            sdata_reg <= store_mem[rp_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[lwp_reg] <= len_wdata;
        end
        if (len_re) begin
            len_rd_reg <= len_mem[lrp_reg];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_q_reg, out_smp_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/chunked_sample_fifo_with_overflow_unit.sv =====
// push samples go in one per cycle while the output register is free; a packet head passes
// the cut and admit states before its result is loaded; a head or a pop holds the input
// a pop passes its pop and length states, then streams n samples one per cycle if not stalled
// an empty pop loads its result in the pop state; a waiting result holds the input
// reset clears pointers, counts and the overflow flag; capacity 4096, max chunk 64
// store contents are undefined after reset and need no clearing pass
`default_nettype none

module chunked_sample_fifo_with_overflow_unit #(
    parameter int STORE_DEPTH = 4096,
    parameter int CHUNK_LIMIT = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // sample_in [15:0], packet_length [31:16]
    input  wire logic [csf_pkg::TDATA_W-1:0]         s_tdata,
    // req_type [1:0], packet_first [2]
    input  wire logic [csf_pkg::TUSER_IN_W-1:0]      s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // sample_out [15:0], queued_count [28:16], zero [31:29]
    output logic [csf_pkg::TDATA_W-1:0]              m_tdata,
    // kind [2:0]
    output logic [csf_pkg::TUSER_OUT_W-1:0]          m_tuser,
    // chunk_last
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [csf_pkg::CAP_W-1:0]           cfg_data
);
    import csf_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    csf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req      (req_t'(s_tuser[1:0])),
        .first    (s_tuser[2]),
        .status   (status),
        .cmd      (cmd)
    );

    csf_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .CHUNK_LIMIT (CHUNK_LIMIT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .smp_in    (s_tdata[SAMPLE_W-1:0]),
        .len_in    (s_tdata[SAMPLE_W+LEN_W-1:SAMPLE_W]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the chunked sample fifo with random packet, pop and clear traffic
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import csf_pkg::*;

    localparam int DEPTH          = 4096;
    localparam int CHUNK_MAX      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASE_ITEMS    = 45;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]          kind;
        logic [SAMPLE_W-1:0] smp;
        logic                is_last;
        logic [QCOUNT_W-1:0] qcount;
    } fifo_result_t;

    // mirrors the fifo state and keeps the results still owed by the block
    class fifo_tracker;
        logic [SAMPLE_W:0] sample_mem [DEPTH];
        int unsigned rd_ptr = 0, wr_ptr = 0, queued = 0, chunks = 0, owed = 0, fill = 0;
        bit overflow = 1'b0;
        int unsigned capacity = 4096, max_chunk = 64;
        fifo_result_t due_results[$];
        int unsigned failures = 0;

        function int unsigned cap_limit();
            if (capacity < 1) return 1;
            if (capacity > DEPTH) return DEPTH;
            return capacity;
        endfunction

        function int unsigned chunk_limit();
            if (max_chunk < 1) return 1;
            if (max_chunk > CHUNK_MAX) return CHUNK_MAX;
            return max_chunk;
        endfunction

        // free space is zero while the queue sits above a lowered capacity
        function int unsigned free_space();
            return (queued < cap_limit()) ? cap_limit() - queued : 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CAP_W-1:0] data);
            if (idx == CFG_CAPACITY) capacity = data;
            else max_chunk = data[MAXC_W-1:0];
        endfunction

        function void expect_single(kind_t kind);
            fifo_result_t r;
            r.kind    = kind;
            r.smp     = '0;
            r.is_last = 1'b1;
            r.qcount  = QCOUNT_W'(queued);
            due_results.push_back(r);
        endfunction

        function void write_sample(logic [SAMPLE_W-1:0] smp);
            bit end_mark;
            fill++;
            owed--;
            end_mark = (fill >= chunk_limit()) || (owed == 0);
            sample_mem[wr_ptr] = {end_mark, smp};
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (end_mark) begin
                fill = 0;
                chunks++;
            end
        endfunction

        // a new packet head ends the open one: release what it still owed
        function void cut_packet();
            if (owed == 0) return;
            queued = (queued >= owed) ? queued - owed : 0;
            owed = 0;
            if (fill > 0) begin
                sample_mem[(wr_ptr + DEPTH - 1) % DEPTH][SAMPLE_W] = 1'b1;
                fill = 0;
                chunks++;
            end
        endfunction

        // returns 1 when the item changes anything
        function bit note_item(logic [1:0] req, logic [SAMPLE_W-1:0] smp, logic first,
                               logic [LEN_W-1:0] len);
            fifo_result_t chunk_q[$];
            fifo_result_t r;
            logic [SAMPLE_W:0] w;
            bit is_last;
            case (req)
                REQ_PUSH: begin
                    if (!first) begin
                        if (owed == 0) return 1'b0;
                        write_sample(smp);
                        return 1'b1;
                    end
                    cut_packet();
                    if (len == 0) begin
                        expect_single(KIND_ACCEPTED);
                    end else if (len > free_space()) begin
                        if (overflow) expect_single(KIND_OVF_ONGOING);
                        else expect_single(KIND_OVF_START);
                        overflow = 1'b1;
                    end else begin
                        owed = len;
                        queued += len;
                        write_sample(smp);
                        expect_single(KIND_ACCEPTED);
                    end
                    return 1'b1;
                end
                REQ_POP: begin
                    if (chunks == 0) begin
                        expect_single(KIND_POP_EMPTY);
                        return 1'b1;
                    end
                    do begin
                        w = sample_mem[rd_ptr];
                        is_last = w[SAMPLE_W] || (chunk_q.size() == CHUNK_MAX - 1);
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        if (queued > 0) queued--;
                        r.kind    = KIND_POPPED;
                        r.smp     = w[SAMPLE_W-1:0];
                        r.is_last = is_last;
                        chunk_q.push_back(r);
                    end while (!is_last);
                    chunks--;
                    if (overflow && queued <= (cap_limit() - 1) / 2) overflow = 1'b0;
                    // every item of the chunk carries the count after the whole pop
                    foreach (chunk_q[i]) begin
                        chunk_q[i].qcount = QCOUNT_W'(queued);
                        due_results.push_back(chunk_q[i]);
                    end
                    return 1'b1;
                end
                REQ_CLEAR: begin
                    rd_ptr   = 0;
                    wr_ptr   = 0;
                    queued   = 0;
                    chunks   = 0;
                    overflow = 1'b0;
                    owed     = 0;
                    fill     = 0;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [SAMPLE_W-1:0] smp, logic is_last,
                                   logic [QCOUNT_W-1:0] qcount);
            fifo_result_t e;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d sample %h", kind, smp);
                failures++;
                return;
            end
            e = due_results.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, kind);
                failures++;
            end
            if (smp !== e.smp) begin
                $error("sample_out: expected %h, got %h", e.smp, smp);
                failures++;
            end
            if (is_last !== e.is_last) begin
                $error("chunk_last: expected %0d, got %0d", e.is_last, is_last);
                failures++;
            end
            if (qcount !== e.qcount) begin
                $error("queued_count: expected %0d, got %0d", e.qcount, qcount);
                failures++;
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;
    logic [TUSER_IN_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [CAP_W-1:0]       cfg_data  = '0;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned sent_items    = 0;
    int unsigned idle_cycles   = 0;

    fifo_tracker sb = new();

    chunked_sample_fifo_with_overflow_unit dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                void'(sb.note_item(s_tuser[1:0], s_tdata[SAMPLE_W-1:0], s_tuser[2],
                                   s_tdata[SAMPLE_W +: LEN_W]));
                sent_items <= sent_items + 1;
            end
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_idx_t'(cfg_index), cfg_data);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[SAMPLE_W-1:0], m_tlast,
                                m_tdata[SAMPLE_W +: QCOUNT_W]);
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(15))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [1:0] req, logic [SAMPLE_W-1:0] smp, logic first,
                             logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, smp};
        s_tuser  <= {first, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic configure(logic [CAP_W-1:0] cap, logic [CAP_W-1:0] chunk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_MAX_CHUNK;
        cfg_data  <= chunk;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // s_tvalid is dropped and the clock waited on, so the last item is noted before the queue is looked at
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_traffic(int unsigned goal);
        int unsigned stop_at, pick, len, room, n_samp;
        stop_at = sent_items + goal;
        while (sent_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                room = sb.free_space();
                case ($urandom_range(9))
                    0: len = $urandom_range(65535);
                    1: len = (room < 64) ? room + 1 : $urandom_range(8);
                    2: len = (room < 64) ? room : $urandom_range(8);
                    3: len = sb.chunk_limit() + $urandom_range(1);
                    default: len = $urandom_range(12);
                endcase
                send_item(REQ_PUSH, rand_sample(), 1'b1, LEN_W'(len));
                n_samp = (len > 0) ? len - 1 : 0;
                if (n_samp > 66) n_samp = $urandom_range(66);
                pick = $urandom_range(19);
                if (pick == 0 && n_samp > 0) n_samp = $urandom_range(n_samp - 1);
                else if (pick == 1) n_samp += $urandom_range(1, 3);
                repeat (n_samp) send_item(REQ_PUSH, rand_sample(), 1'b0, LEN_W'($urandom));
            end else if (pick < 82) begin
                send_item(REQ_POP, SAMPLE_W'($urandom), 1'($urandom), LEN_W'($urandom));
            end else if (pick < 87) begin
                send_item(REQ_CLEAR, SAMPLE_W'($urandom), 1'($urandom), LEN_W'($urandom));
            end else if (pick < 92) begin
                send_item(REQ_UNUSED, SAMPLE_W'($urandom), 1'($urandom), LEN_W'($urandom));
            end else begin
                send_item(REQ_PUSH, rand_sample(), 1'b0, LEN_W'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned mode;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small queue so that overflow and its release are reached quickly
        configure(13'd8, 13'd3);
        send_item(REQ_POP, 16'h0000, 1'b0, 16'h0000);
        send_item(REQ_PUSH, 16'h1234, 1'b1, 16'd0);
        send_item(REQ_PUSH, 16'h4321, 1'b0, 16'd0);
        send_item(REQ_UNUSED, 16'hffff, 1'b1, 16'hffff);
        send_item(REQ_PUSH, 16'h8000, 1'b1, 16'd4);
        send_item(REQ_PUSH, 16'h7fff, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'h0000, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'hffff, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'h5555, 1'b1, 16'hffff);
        send_item(REQ_PUSH, 16'haaaa, 1'b1, 16'd5);
        send_item(REQ_PUSH, 16'h0001, 1'b0, 16'd0);
        // drops below half the capacity, so the overflow flag goes
        send_item(REQ_POP, 16'hffff, 1'b1, 16'hffff);
        // exactly fills the free space, then gets cut short mid chunk
        send_item(REQ_PUSH, 16'h0102, 1'b1, 16'd7);
        send_item(REQ_PUSH, 16'h0304, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'h0506, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'h0708, 1'b0, 16'd0);
        send_item(REQ_PUSH, 16'h0a0b, 1'b1, 16'd1);
        repeat (5) send_item(REQ_POP, 16'h0000, 1'b0, 16'h0000);
        send_item(REQ_PUSH, 16'hbeef, 1'b1, 16'd6);
        send_item(REQ_PUSH, 16'hcafe, 1'b0, 16'd0);
        send_item(REQ_CLEAR, 16'hffff, 1'b1, 16'hffff);
        send_item(REQ_POP, 16'h0000, 1'b0, 16'h0000);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(13'd4096, 13'd64);
                1: configure(13'd0, 13'd0);
                2: configure(13'd8191, 13'd127);
                3: configure(13'd24, 13'd5);
                4: configure(13'd12, 13'd64);
                default: configure(CAP_W'($urandom_range(2, 64)), CAP_W'($urandom_range(1, 16)));
            endcase
            mode = p % 4;
            send_idle_pct <= (mode == 1) ? 74 : ((mode == 3) ? 30 : 0);
            stall_pct     <= (mode == 2) ? 74 : ((mode == 3) ? 30 : 0);
            run_traffic(PHASE_ITEMS);
            drain();
        end

        if (sb.failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/csf_pkg.sv
rtl/csf_ctrl.sv
rtl/csf_datapath.sv
rtl/chunked_sample_fifo_with_overflow_unit.sv
verif/testbench.sv
